// ===== src/fnvh_pkg.sv =====
// Shared types, constants and hash arithmetic for the FNV-1a key hasher.
`default_nettype none
package fnvh_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CntW = 6;

  localparam logic [CfgIdxW-1:0] REG_WIDE_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TABLE_SIZE = 2'd1;

  localparam logic [63:0] FNV32_BASIS = 64'd2166136261;
  localparam logic [63:0] FNV64_BASIS = 64'd14695981039346656037;
  localparam logic [31:0] TABLE_SIZE_RESET = 32'd4096;

  // Division passes: one quotient bit per cycle over the live width of the hash.
  localparam logic [CntW-1:0] DIV_LAST32 = 6'd31;
  localparam logic [CntW-1:0] DIV_LAST64 = 6'd63;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       key_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] full_hash;
    logic [31:0] bucket_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } sts_t;

  function automatic logic [63:0] fnv_basis(input logic wide);
    return wide ? FNV64_BASIS : FNV32_BASIS;
  endfunction

  // XOR the byte in, then multiply by the prime as a constant shift-add.
  // 32-bit prime is 2^24 + 0x193, 64-bit prime is 2^40 + 0x1B3.
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b,
                                          input logic wide);
    logic [31:0] x32;
    logic [31:0] p32;
    logic [63:0] x64;
    logic [63:0] p64;
    x32 = h[31:0] ^ {24'd0, b};
    p32 = x32 + (x32 << 1) + (x32 << 4) + (x32 << 7) + (x32 << 8) + (x32 << 24);
    x64 = h ^ {56'd0, b};
    p64 = x64 + (x64 << 1) + (x64 << 4) + (x64 << 5) + (x64 << 7) + (x64 << 8)
        + (x64 << 40);
    return wide ? p64 : {32'd0, p32};
  endfunction

endpackage
`default_nettype wire

// ===== src/fnv1a_hash_table_index.sv =====
// Top level of the FNV-1a key hasher with bucket index.
// Keys arrive one byte per item; each byte item is taken while the block is idle, the
// hash being updated by a constant shift-add multiply. An item with key_end set is
// followed by a bit-serial remainder of the hash by table_size over 32 bits in
// 32-bit mode or 64 bits in 64-bit mode, then by a hand-off of the result to the
// output register; no new item is taken until the hand-off is done, and it waits
// while the previous result is still held in the output register. The output
// register lets the next key stream in while a result waits to be taken. A
// table_size of zero gives a bucket index of zero. Writing wide_mode restarts
// any key in progress from the offset basis of the new mode.
`default_nettype none
module fnv1a_hash_table_index (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fnvh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fnvh_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire fnvh_pkg::in_item_t            in_item_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  output fnvh_pkg::out_item_t                out_item_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i
);
  import fnvh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fnvh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_key_end_i (in_item_i.key_end),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  fnvh_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

// ===== src/fnvh_ctrl.sv =====
// Controller: item handshakes, division sequencing and result hand-off.
`default_nettype none
module fnvh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          in_key_end_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fnvh_pkg::cmd_t     cmd_o,
  input  wire fnvh_pkg::sts_t sts_i
);
  import fnvh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_key_end_i) begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // The finished result waits here until the output register is free.
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/fnvh_datapath.sv =====
// Datapath: configuration, running hash, serial remainder unit and result register.
`default_nettype none
module fnvh_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fnvh_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [fnvh_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire fnvh_pkg::in_item_t                in_item_i,
  input  wire fnvh_pkg::cmd_t                    cmd_i,
  output fnvh_pkg::sts_t                         sts_o,
  output fnvh_pkg::out_item_t                    out_item_o
);
  import fnvh_pkg::*;

  logic            wide_q;
  logic [31:0]     tsize_q;
  logic [63:0]     hash_q, hash_d;
  logic [63:0]     mixed;
  logic [63:0]     key_hash;
  logic [63:0]     res_hash_q;
  logic [63:0]     dvd_q, dvd_d;
  logic [31:0]     rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0]     trial;
  logic [32:0]     trial_sub;
  out_item_t       out_q;

  assign mixed    = fnv_mix(hash_q, in_item_i.key_byte, wide_q);
  assign key_hash = in_item_i.byte_valid ? mixed : hash_q;

  // Configuration registers; a mode write restarts the key from the new basis.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= 1'b0;
      tsize_q <= TABLE_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDE_MODE:  wide_q  <= cfg_data_i[0];
        REG_TABLE_SIZE: tsize_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (cfg_we_i && (cfg_idx_i == REG_WIDE_MODE)) begin
      hash_d = fnv_basis(cfg_data_i[0]);
    end else if (cmd_i.accept) begin
      hash_d = in_item_i.key_end ? fnv_basis(wide_q) : key_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV32_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

  // Restoring remainder: shift one dividend bit in per cycle, subtract if it fits.
  // The remainder stays below the divisor, so the trial needs only one extra bit.
  assign trial     = {rem_q, dvd_q[63]};
  assign trial_sub = trial - {1'b0, tsize_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.start_div) begin
      dvd_d = wide_q ? key_hash : {key_hash[31:0], 32'd0};
      rem_d = '0;
      cnt_d = wide_q ? DIV_LAST64 : DIV_LAST32;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      rem_d = (trial >= {1'b0, tsize_q}) ? trial_sub[31:0] : trial[31:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (cmd_i.start_div) begin
      res_hash_q <= key_hash;
    end
    if (cmd_i.load_out) begin
      out_q.full_hash    <= res_hash_q;
      out_q.bucket_index <= (tsize_q == '0) ? 32'd0 : rem_q;
    end
  end

  assign out_item_o = out_q;

endmodule
`default_nettype wire
